### hw/rtl/ots_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ots_pkg;

	localparam int DIST_W  = 10;
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 16;
	localparam int SPEED_W = 9;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	// item kinds
	localparam logic [1:0] KIND_BEGIN    = 2'd0;
	localparam logic [1:0] KIND_SEARCH   = 2'd1;
	localparam logic [1:0] KIND_APPROACH = 2'd2;

	// result actions
	localparam logic [1:0] ACT_IDLE   = 2'd0;
	localparam logic [1:0] ACT_DRIVE  = 2'd1;
	localparam logic [1:0] ACT_ATTACK = 2'd2;

	// seen direction codes
	localparam logic signed [1:0] DIR_LEFT   = -2'sd1;
	localparam logic signed [1:0] DIR_CENTRE = 2'sd0;
	localparam logic signed [1:0] DIR_RIGHT  = 2'sd1;

	// register indexes
	localparam logic [2:0] REG_DETECT_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_FIRST_ARC_MS     = 3'd1;
	localparam logic [2:0] REG_ARC_FLIP_MS      = 3'd2;
	localparam logic [2:0] REG_SIDE_CONFIRM_MS  = 3'd3;
	localparam logic [2:0] REG_ERROR_DEADBAND   = 3'd4;
	localparam logic [2:0] REG_MAX_CORRECTION   = 3'd5;
	localparam logic [2:0] REG_BASE_SPEED       = 3'd6;
	localparam logic [2:0] REG_PUSH_MAX_TRIM    = 3'd7;

	// register reset values
	localparam logic [9:0]  RST_DETECT_THRESHOLD = 10'd300;
	localparam logic [15:0] RST_FIRST_ARC_MS     = 16'd500;
	localparam logic [15:0] RST_ARC_FLIP_MS      = 16'd1000;
	localparam logic [15:0] RST_SIDE_CONFIRM_MS  = 16'd50;
	localparam logic [9:0]  RST_ERROR_DEADBAND   = 10'd20;
	localparam logic [7:0]  RST_MAX_CORRECTION   = 8'd120;
	localparam logic [7:0]  RST_BASE_SPEED       = 8'd150;
	localparam logic [7:0]  RST_PUSH_MAX_TRIM    = 8'd40;

	// steering gain and search wheel speeds
	localparam int KP_NUM      = 1;
	localparam int KP_DEN      = 2;
	localparam int KP_DIV      = (KP_DEN != 0) ? KP_DEN : 1;
	localparam int SEARCH_SLOW = 80;
	localparam int SEARCH_FAST = 180;

	localparam int SLOW_SAT = (SEARCH_SLOW < -255) ? -255 :
		((SEARCH_SLOW > 255) ? 255 : SEARCH_SLOW);
	localparam int FAST_SAT = (SEARCH_FAST < -255) ? -255 :
		((SEARCH_FAST > 255) ? 255 : SEARCH_FAST);
	localparam logic signed [SPEED_W-1:0] SLOW_SPEED = SPEED_W'(SLOW_SAT);
	localparam logic signed [SPEED_W-1:0] FAST_SPEED = SPEED_W'(FAST_SAT);

	// clamp a wide signed value to -lim..lim
	function automatic logic signed [SPEED_W-1:0] clamp_sym(
		input logic signed [19:0] v,
		input logic [7:0]         lim
	);
		logic signed [19:0] hi;
		logic signed [19:0] lo;
		hi = $signed({12'd0, lim});
		lo = -hi;
		if (v > hi) begin
			return SPEED_W'(hi);
		end else if (v < lo) begin
			return SPEED_W'(lo);
		end
		return SPEED_W'(v);
	endfunction

endpackage

`default_nettype wire

### hw/rtl/ots_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface ots_sample_if import ots_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [TIME_W-1:0] now_ms;
	logic              initial_dir;
	logic [DIST_W-1:0] front_left;
	logic [DIST_W-1:0] front_right;
	logic [DIST_W-1:0] side_left;
	logic [DIST_W-1:0] side_right;
	logic              attack_window_open;

	modport source (
		output valid, kind, now_ms, initial_dir, front_left, front_right,
		       side_left, side_right, attack_window_open,
		input  ready
	);
	modport sink (
		input  valid, kind, now_ms, initial_dir, front_left, front_right,
		       side_left, side_right, attack_window_open,
		output ready
	);
endinterface

interface ots_result_if import ots_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                action;
	logic signed [SPEED_W-1:0] left_speed;
	logic signed [SPEED_W-1:0] right_speed;
	logic signed [SPEED_W-1:0] attack_trim;
	logic [DIST_W-1:0]         attack_strength;
	logic signed [SPEED_W-1:0] last_correction;
	logic signed [1:0]         last_seen_dir;

	modport source (
		output valid, action, left_speed, right_speed, attack_trim,
		       attack_strength, last_correction, last_seen_dir,
		input  ready
	);
	modport sink (
		input  valid, action, left_speed, right_speed, attack_trim,
		       attack_strength, last_correction, last_seen_dir,
		output ready
	);
endinterface

`default_nettype wire

### hw/rtl/opponent_tracking_steering.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake      payload
// sample    in         valid/ready    kind, now_ms, initial_dir, four readings, window
// result    out        valid/ready    action, speeds, trim, strength, memos
// apb       in         psel/penable   eight registers at byte address 4*i
//
// result valid after the sample transfer passes the input register, then the result register
// one item per cycle sustained; the tracking state updates as an item enters the result register
// a full result register that is not taken holds the input register, and sample.ready drops
// arst_n clears the tracking state and loads the register defaults
module opponent_tracking_steering import ots_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ots_sample_if.sink        sample,
	ots_result_if.source      result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// configuration registers
	logic [9:0]  detect_threshold_q;
	logic [15:0] first_arc_ms_q;
	logic [15:0] arc_flip_ms_q;
	logic [15:0] side_confirm_ms_q;
	logic [9:0]  error_deadband_q;
	logic [7:0]  max_correction_q;
	logic [7:0]  base_speed_q;
	logic [7:0]  push_max_trim_q;

	logic       cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detect_threshold_q <= RST_DETECT_THRESHOLD;
			first_arc_ms_q     <= RST_FIRST_ARC_MS;
			arc_flip_ms_q      <= RST_ARC_FLIP_MS;
			side_confirm_ms_q  <= RST_SIDE_CONFIRM_MS;
			error_deadband_q   <= RST_ERROR_DEADBAND;
			max_correction_q   <= RST_MAX_CORRECTION;
			base_speed_q       <= RST_BASE_SPEED;
			push_max_trim_q    <= RST_PUSH_MAX_TRIM;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_DETECT_THRESHOLD: detect_threshold_q <= pwdata[9:0];
				REG_FIRST_ARC_MS:     first_arc_ms_q     <= pwdata[15:0];
				REG_ARC_FLIP_MS:      arc_flip_ms_q      <= pwdata[15:0];
				REG_SIDE_CONFIRM_MS:  side_confirm_ms_q  <= pwdata[15:0];
				REG_ERROR_DEADBAND:   error_deadband_q   <= pwdata[9:0];
				REG_MAX_CORRECTION:   max_correction_q   <= pwdata[7:0];
				REG_BASE_SPEED:       base_speed_q       <= pwdata[7:0];
				REG_PUSH_MAX_TRIM:    push_max_trim_q    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_DETECT_THRESHOLD: prdata = DATA_W'(detect_threshold_q);
			REG_FIRST_ARC_MS:     prdata = DATA_W'(first_arc_ms_q);
			REG_ARC_FLIP_MS:      prdata = DATA_W'(arc_flip_ms_q);
			REG_SIDE_CONFIRM_MS:  prdata = DATA_W'(side_confirm_ms_q);
			REG_ERROR_DEADBAND:   prdata = DATA_W'(error_deadband_q);
			REG_MAX_CORRECTION:   prdata = DATA_W'(max_correction_q);
			REG_BASE_SPEED:       prdata = DATA_W'(base_speed_q);
			REG_PUSH_MAX_TRIM:    prdata = DATA_W'(push_max_trim_q);
			default:              prdata = '0;
		endcase
	end

	// input register
	logic              valid_s1;
	logic [1:0]        kind_s1;
	logic [TIME_W-1:0] now_s1;
	logic              dir_s1;
	logic [DIST_W-1:0] fl_s1;
	logic [DIST_W-1:0] fr_s1;
	logic [DIST_W-1:0] sl_s1;
	logic [DIST_W-1:0] sr_s1;
	logic              win_s1;

	logic advance;
	logic take;

	assign advance      = valid_s1 && (!result.valid || result.ready);
	assign sample.ready = !valid_s1 || advance;
	assign take         = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1 <= sample.kind;
			now_s1  <= sample.now_ms;
			dir_s1  <= sample.initial_dir;
			fl_s1   <= sample.front_left;
			fr_s1   <= sample.front_right;
			sl_s1   <= sample.side_left;
			sr_s1   <= sample.side_right;
			win_s1  <= sample.attack_window_open;
		end
	end

	// tracking state
	logic                      arc_dir_q;
	logic [TIME_W-1:0]         arc_switch_q;
	logic                      first_arc_done_q;
	logic signed [SPEED_W-1:0] active_q;
	logic signed [SPEED_W-1:0] pending_q;
	logic [TIME_W-1:0]         pending_since_q;
	logic signed [SPEED_W-1:0] corr_memo_q;
	logic signed [1:0]         seen_memo_q;

	logic                      arc_dir_n;
	logic [TIME_W-1:0]         arc_switch_n;
	logic                      first_arc_done_n;
	logic signed [SPEED_W-1:0] active_n;
	logic signed [SPEED_W-1:0] pending_n;
	logic [TIME_W-1:0]         pending_since_n;
	logic signed [SPEED_W-1:0] corr_memo_n;
	logic signed [1:0]         seen_memo_n;

	logic [1:0]                action_c;
	logic signed [SPEED_W-1:0] lsp_c;
	logic signed [SPEED_W-1:0] rsp_c;
	logic signed [SPEED_W-1:0] trim_c;
	logic [DIST_W-1:0]         strength_c;

	// approach datapath
	logic                      fls, frs, ls, rs;
	logic signed [10:0]        delta;
	logic [10:0]               abs_delta;
	logic signed [19:0]        delta_ext;
	logic signed [19:0]        scaled;
	logic signed [19:0]        quot;
	logic signed [SPEED_W-1:0] mc;
	logic signed [SPEED_W-1:0] req;
	logic signed [SPEED_W-1:0] corr;
	logic signed [10:0]        sum_l, sum_r;
	logic [DIST_W-1:0]         fmax;
	logic                      push;
	logic [TIME_W-1:0]         arc_elapsed;
	logic [TIME_W-1:0]         arc_interval;
	logic [TIME_W-1:0]         pend_elapsed;

	always_comb begin
		fls       = fl_s1 >= detect_threshold_q;
		frs       = fr_s1 >= detect_threshold_q;
		ls        = sl_s1 >= detect_threshold_q;
		rs        = sr_s1 >= detect_threshold_q;
		delta     = $signed({1'b0, fr_s1}) - $signed({1'b0, fl_s1});
		abs_delta = delta[10] ? 11'(-delta) : 11'(delta);
		delta_ext = 20'(delta);
		scaled    = 20'(delta_ext * KP_NUM);
		quot      = 20'(scaled / KP_DIV);
		mc        = $signed({1'b0, max_correction_q});
		fmax      = (fl_s1 > fr_s1) ? fl_s1 : fr_s1;

		arc_elapsed  = now_s1 - arc_switch_q;
		arc_interval = TIME_W'(first_arc_done_q ? arc_flip_ms_q : first_arc_ms_q);
		pend_elapsed = now_s1 - pending_since_q;

		req = '0;
		if (!fls && !frs) begin
			if (rs && !ls) begin
				req = mc;
			end else if (ls && !rs) begin
				req = -mc;
			end
		end

		arc_dir_n        = arc_dir_q;
		arc_switch_n     = arc_switch_q;
		first_arc_done_n = first_arc_done_q;
		active_n         = active_q;
		pending_n        = pending_q;
		pending_since_n  = pending_since_q;
		corr_memo_n      = corr_memo_q;
		seen_memo_n      = seen_memo_q;

		action_c   = ACT_IDLE;
		lsp_c      = '0;
		rsp_c      = '0;
		trim_c     = '0;
		strength_c = '0;
		corr       = '0;
		sum_l      = '0;
		sum_r      = '0;
		push       = 1'b0;

		unique case (kind_s1)
			KIND_BEGIN: begin
				arc_dir_n        = dir_s1;
				arc_switch_n     = now_s1;
				first_arc_done_n = 1'b0;
				active_n         = '0;
				pending_n        = '0;
				pending_since_n  = '0;
				corr_memo_n      = '0;
				seen_memo_n      = DIR_CENTRE;
			end
			KIND_SEARCH: begin
				if (arc_elapsed >= arc_interval) begin
					arc_dir_n        = !arc_dir_q;
					arc_switch_n     = now_s1;
					first_arc_done_n = 1'b1;
				end
				action_c = ACT_DRIVE;
				lsp_c    = arc_dir_n ? FAST_SPEED : SLOW_SPEED;
				rsp_c    = arc_dir_n ? SLOW_SPEED : FAST_SPEED;
			end
			KIND_APPROACH: begin
				// side override: needs a steady request for the confirm time
				priority if (req == '0) begin
					active_n  = '0;
					pending_n = '0;
				end else if (req == active_q) begin
					pending_n = '0;
				end else if (pending_q != req) begin
					pending_n       = req;
					pending_since_n = now_s1;
				end else if (pend_elapsed >= TIME_W'(side_confirm_ms_q)) begin
					active_n  = req;
					pending_n = '0;
				end else begin
					// request still waiting out the confirm time
				end

				if (active_n != '0) begin
					corr = active_n;
				end else if (abs_delta >= {1'b0, error_deadband_q}) begin
					corr = clamp_sym(quot, max_correction_q);
				end

				priority if (fls && frs) begin
					seen_memo_n = DIR_CENTRE;
				end else if (frs) begin
					seen_memo_n = DIR_RIGHT;
				end else if (fls) begin
					seen_memo_n = DIR_LEFT;
				end else if (rs && !ls) begin
					seen_memo_n = DIR_RIGHT;
				end else if (ls && !rs) begin
					seen_memo_n = DIR_LEFT;
				end else begin
					seen_memo_n = DIR_CENTRE;
				end

				push = (active_n == '0) && ((fls && frs) || (win_s1 && (fls || frs)));
				if (push) begin
					trim_c      = clamp_sym(20'(corr), push_max_trim_q);
					corr_memo_n = trim_c;
					action_c    = ACT_ATTACK;
					strength_c  = fmax;
				end else begin
					corr_memo_n = corr;
					action_c    = ACT_DRIVE;
					sum_l       = $signed({3'd0, base_speed_q}) + 11'(corr);
					sum_r       = $signed({3'd0, base_speed_q}) - 11'(corr);
					lsp_c       = clamp_sym(20'(sum_l), 8'd255);
					rsp_c       = clamp_sym(20'(sum_r), 8'd255);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arc_dir_q        <= 1'b0;
			arc_switch_q     <= '0;
			first_arc_done_q <= 1'b0;
			active_q         <= '0;
			pending_q        <= '0;
			pending_since_q  <= '0;
			corr_memo_q      <= '0;
			seen_memo_q      <= DIR_CENTRE;
		end else if (advance) begin
			arc_dir_q        <= arc_dir_n;
			arc_switch_q     <= arc_switch_n;
			first_arc_done_q <= first_arc_done_n;
			active_q         <= active_n;
			pending_q        <= pending_n;
			pending_since_q  <= pending_since_n;
			corr_memo_q      <= corr_memo_n;
			seen_memo_q      <= seen_memo_n;
		end
	end

	// result register
	logic                      out_valid_q;
	logic [1:0]                action_q;
	logic signed [SPEED_W-1:0] lsp_q;
	logic signed [SPEED_W-1:0] rsp_q;
	logic signed [SPEED_W-1:0] trim_q;
	logic [DIST_W-1:0]         strength_q;
	logic signed [SPEED_W-1:0] last_corr_q;
	logic signed [1:0]         last_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q    <= action_c;
			lsp_q       <= lsp_c;
			rsp_q       <= rsp_c;
			trim_q      <= trim_c;
			strength_q  <= strength_c;
			last_corr_q <= corr_memo_n;
			last_seen_q <= seen_memo_n;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.action          = action_q;
	assign result.left_speed      = lsp_q;
	assign result.right_speed     = rsp_q;
	assign result.attack_trim     = trim_q;
	assign result.attack_strength = strength_q;
	assign result.last_correction = last_corr_q;
	assign result.last_seen_dir   = last_seen_q;

	// a pending override never equals the one already in force
	a_pending_differs: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q != '0) |-> (pending_q != active_q))
		else $error("pending override equals active override");

	// a begin transfer gives an idle result with cleared memos
	a_begin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && kind_s1 == KIND_BEGIN) |=>
		(result.valid && result.action == ACT_IDLE && result.last_correction == '0 &&
		 result.last_seen_dir == DIR_CENTRE))
		else $error("begin item did not clear the result");

	// an attack result carries no wheel speeds
	a_attack_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.action == ACT_ATTACK) |->
		(result.left_speed == '0 && result.right_speed == '0))
		else $error("attack result with wheel speeds");

	// input stalls only when both stages are full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (valid_s1 && result.valid && !result.ready))
		else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps

module tb import ots_pkg::*; ();

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int         LIMIT       = 400000;

	typedef struct packed {
		logic [1:0]        kind;
		logic [TIME_W-1:0] now_ms;
		logic              initial_dir;
		logic [DIST_W-1:0] front_left;
		logic [DIST_W-1:0] front_right;
		logic [DIST_W-1:0] side_left;
		logic [DIST_W-1:0] side_right;
		logic              window;
	} sample_t;

	typedef struct packed {
		logic [1:0]                action;
		logic signed [SPEED_W-1:0] left_speed;
		logic signed [SPEED_W-1:0] right_speed;
		logic signed [SPEED_W-1:0] attack_trim;
		logic [DIST_W-1:0]         strength;
		logic signed [SPEED_W-1:0] correction;
		logic signed [1:0]         seen_dir;
	} command_t;

	class steer_scoreboard;
		logic [9:0]  thr;
		logic [15:0] first_ms, flip_ms, confirm_ms;
		logic [9:0]  deadband;
		logic [7:0]  max_corr, base, push_trim;

		bit          arc_dir, first_done;
		logic [31:0] arc_since, pending_t;
		int          active, pending, corr_memo;
		logic signed [1:0] seen_memo;

		command_t commands_due[$];
		int errors;

		function new();
			thr = RST_DETECT_THRESHOLD;
			first_ms = RST_FIRST_ARC_MS;
			flip_ms = RST_ARC_FLIP_MS;
			confirm_ms = RST_SIDE_CONFIRM_MS;
			deadband = RST_ERROR_DEADBAND;
			max_corr = RST_MAX_CORRECTION;
			base = RST_BASE_SPEED;
			push_trim = RST_PUSH_MAX_TRIM;
			arc_dir = 0;
			first_done = 0;
			arc_since = '0;
			pending_t = '0;
			active = 0;
			pending = 0;
			corr_memo = 0;
			seen_memo = DIR_CENTRE;
			errors = 0;
		endfunction

		function int sat(int v, int lo, int hi);
			if (v < lo) begin
				return lo;
			end
			if (v > hi) begin
				return hi;
			end
			return v;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_DETECT_THRESHOLD: thr = val[9:0];
				REG_FIRST_ARC_MS:     first_ms = val[15:0];
				REG_ARC_FLIP_MS:      flip_ms = val[15:0];
				REG_SIDE_CONFIRM_MS:  confirm_ms = val[15:0];
				REG_ERROR_DEADBAND:   deadband = val[9:0];
				REG_MAX_CORRECTION:   max_corr = val[7:0];
				REG_BASE_SPEED:       base = val[7:0];
				REG_PUSH_MAX_TRIM:    push_trim = val[7:0];
				default: ;
			endcase
		endfunction

		function int outstanding();
			return commands_due.size();
		endfunction

		function void note_sample(sample_t s);
			command_t c;
			int fl, fr, delta, mag, mc, req, corr, pm, lsp, rsp, trim, den;
			bit fls, frs, ls, rs;
			logic [31:0] span;
			c = '0;
			lsp = 0;
			rsp = 0;
			trim = 0;
			den = (KP_DEN != 0) ? KP_DEN : 1;
			case (s.kind)
				KIND_BEGIN: begin
					arc_dir = s.initial_dir;
					arc_since = s.now_ms;
					first_done = 0;
					active = 0;
					pending = 0;
					pending_t = '0;
					corr_memo = 0;
					seen_memo = DIR_CENTRE;
					c.action = ACT_IDLE;
				end
				KIND_SEARCH: begin
					span = s.now_ms - arc_since;
					if (span >= (first_done ? {16'd0, flip_ms} : {16'd0, first_ms})) begin
						arc_dir = !arc_dir;
						arc_since = s.now_ms;
						first_done = 1;
					end
					c.action = ACT_DRIVE;
					lsp = arc_dir ? sat(SEARCH_FAST, -255, 255) : sat(SEARCH_SLOW, -255, 255);
					rsp = arc_dir ? sat(SEARCH_SLOW, -255, 255) : sat(SEARCH_FAST, -255, 255);
				end
				KIND_APPROACH: begin
					fl = s.front_left;
					fr = s.front_right;
					fls = s.front_left >= thr;
					frs = s.front_right >= thr;
					ls = s.side_left >= thr;
					rs = s.side_right >= thr;
					delta = fr - fl;
					mag = (delta < 0) ? -delta : delta;
					mc = max_corr;
					req = 0;
					corr = 0;
					if (!fls && !frs) begin
						if (rs && !ls) begin
							req = mc;
						end else if (ls && !rs) begin
							req = -mc;
						end
					end
					// side request must hold for the confirm time, drops out at once
					if (req == 0) begin
						active = 0;
						pending = 0;
					end else if (req == active) begin
						pending = 0;
					end else if (pending != req) begin
						pending = req;
						pending_t = s.now_ms;
					end else begin
						span = s.now_ms - pending_t;
						if (span >= {16'd0, confirm_ms}) begin
							active = req;
							pending = 0;
						end
					end
					if (active != 0) begin
						corr = active;
					end else if (mag >= int'(deadband)) begin
						corr = sat(delta * KP_NUM / den, -mc, mc);
					end
					if (fls && frs) begin
						seen_memo = DIR_CENTRE;
					end else if (frs) begin
						seen_memo = DIR_RIGHT;
					end else if (fls) begin
						seen_memo = DIR_LEFT;
					end else if (rs && !ls) begin
						seen_memo = DIR_RIGHT;
					end else if (ls && !rs) begin
						seen_memo = DIR_LEFT;
					end else begin
						seen_memo = DIR_CENTRE;
					end
					corr_memo = corr;
					if (active == 0 && ((fls && frs) || (s.window && (fls || frs)))) begin
						pm = push_trim;
						trim = sat(corr, -pm, pm);
						corr_memo = trim;
						c.action = ACT_ATTACK;
						c.strength = (fl > fr) ? s.front_left : s.front_right;
					end else begin
						c.action = ACT_DRIVE;
						lsp = sat(int'(base) + corr, -255, 255);
						rsp = sat(int'(base) - corr, -255, 255);
					end
				end
				default: c.action = ACT_IDLE;
			endcase
			c.left_speed = lsp[SPEED_W-1:0];
			c.right_speed = rsp[SPEED_W-1:0];
			c.attack_trim = trim[SPEED_W-1:0];
			c.correction = corr_memo[SPEED_W-1:0];
			c.seen_dir = seen_memo;
			commands_due.push_back(c);
		endfunction

		function void field(string name, logic signed [31:0] want, logic signed [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(command_t got);
			command_t want;
			if (commands_due.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
				return;
			end
			want = commands_due.pop_front();
			field("action", {30'd0, want.action}, {30'd0, got.action});
			field("left_speed", want.left_speed, got.left_speed);
			field("right_speed", want.right_speed, got.right_speed);
			field("attack_trim", want.attack_trim, got.attack_trim);
			field("attack_strength", {22'd0, want.strength}, {22'd0, got.strength});
			field("last_correction", want.correction, got.correction);
			field("last_seen_dir", want.seen_dir, got.seen_dir);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	ots_sample_if smp ();
	ots_result_if res ();

	opponent_tracking_steering dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (smp),
		.result  (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	steer_scoreboard sb = new();

	bit          tx_idle_on;
	bit          rx_idle_on;
	int          long_hold;
	int          items_sent;
	int          cycles;
	logic [31:0] clock_ms;
	logic [9:0]  thr_now;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb failed");
		$finish;
	end

	// watch both channels at the rising edge
	initial begin
		command_t got;
		forever begin
			@(posedge clk);
			if (arst_n && smp.valid && smp.ready) begin
				sb.note_sample({smp.kind, smp.now_ms, smp.initial_dir, smp.front_left,
					smp.front_right, smp.side_left, smp.side_right, smp.attack_window_open});
			end
			if (arst_n && res.valid && res.ready) begin
				got.action = res.action;
				got.left_speed = res.left_speed;
				got.right_speed = res.right_speed;
				got.attack_trim = res.attack_trim;
				got.strength = res.attack_strength;
				got.correction = res.last_correction;
				got.seen_dir = res.last_seen_dir;
				sb.check_result(got);
			end
		end
	end

	// result side back-pressure, long hold counted here
	initial begin
		int gap;
		gap = 0;
		res.ready = 0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				res.ready = 0;
			end else if (long_hold > 0) begin
				res.ready = 0;
				long_hold--;
			end else if (gap > 0) begin
				res.ready = 0;
				gap--;
			end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
				res.ready = 0;
				gap = $urandom_range(1, 10) - 1;
			end else begin
				res.ready = 1;
			end
		end
	end

	function automatic sample_t mk(logic [1:0] kind, logic [31:0] now, logic dir,
			logic [9:0] fl, logic [9:0] fr, logic [9:0] sl, logic [9:0] sr, logic win);
		sample_t s;
		s.kind = kind;
		s.now_ms = now;
		s.initial_dir = dir;
		s.front_left = fl;
		s.front_right = fr;
		s.side_left = sl;
		s.side_right = sr;
		s.window = win;
		return s;
	endfunction

	function automatic logic [31:0] next_ms();
		case ($urandom_range(0, 19))
			0: clock_ms = $urandom;
			1, 2: clock_ms = clock_ms + $urandom_range(0, 3000);
			default: clock_ms = clock_ms + $urandom_range(0, 40);
		endcase
		return clock_ms;
	endfunction

	// readings cluster on the detection level so both sides of it are hit
	function automatic logic [9:0] reading();
		case ($urandom_range(0, 5))
			0: return 10'd0;
			1: return 10'h3FF;
			2: return thr_now;
			3: return (thr_now == 0) ? 10'd0 : thr_now - 10'd1;
			default: return 10'($urandom_range(0, 1023));
		endcase
	endfunction

	task automatic send(input sample_t s);
		int gap;
		smp.kind = s.kind;
		smp.now_ms = s.now_ms;
		smp.initial_dir = s.initial_dir;
		smp.front_left = s.front_left;
		smp.front_right = s.front_right;
		smp.side_left = s.side_left;
		smp.side_right = s.side_right;
		smp.attack_window_open = s.window;
		smp.valid = 1;
		@(posedge clk);
		while (!smp.ready) @(posedge clk);
		items_sent++;
		@(negedge clk);
		if (tx_idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 10);
			smp.valid = 0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic settle();
		smp.valid = 0;
		while (sb.outstanding() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		psel = 1;
		penable = 0;
		pwrite = 1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.write_reg(idx, val);
		if (idx == REG_DETECT_THRESHOLD) begin
			thr_now = val[9:0];
		end
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	task automatic configure(input int phase);
		logic [31:0] v[8];
		case (phase)
			0: begin
				v[REG_DETECT_THRESHOLD] = RST_DETECT_THRESHOLD;
				v[REG_FIRST_ARC_MS] = RST_FIRST_ARC_MS;
				v[REG_ARC_FLIP_MS] = RST_ARC_FLIP_MS;
				v[REG_SIDE_CONFIRM_MS] = RST_SIDE_CONFIRM_MS;
				v[REG_ERROR_DEADBAND] = RST_ERROR_DEADBAND;
				v[REG_MAX_CORRECTION] = RST_MAX_CORRECTION;
				v[REG_BASE_SPEED] = RST_BASE_SPEED;
				v[REG_PUSH_MAX_TRIM] = RST_PUSH_MAX_TRIM;
			end
			1: begin
				foreach (v[i]) v[i] = '0;
			end
			2: begin
				v[REG_DETECT_THRESHOLD] = 1023;
				v[REG_FIRST_ARC_MS] = 65535;
				v[REG_ARC_FLIP_MS] = 65535;
				v[REG_SIDE_CONFIRM_MS] = 65535;
				v[REG_ERROR_DEADBAND] = 1023;
				v[REG_MAX_CORRECTION] = 255;
				v[REG_BASE_SPEED] = 255;
				v[REG_PUSH_MAX_TRIM] = 255;
			end
			default: begin
				v[REG_DETECT_THRESHOLD] = $urandom_range(0, 1023);
				v[REG_FIRST_ARC_MS] = $urandom_range(0, 400);
				v[REG_ARC_FLIP_MS] = $urandom_range(0, 600);
				v[REG_SIDE_CONFIRM_MS] = $urandom_range(0, 150);
				v[REG_ERROR_DEADBAND] = $urandom_range(0, 200);
				v[REG_MAX_CORRECTION] = $urandom_range(0, 255);
				v[REG_BASE_SPEED] = $urandom_range(0, 255);
				v[REG_PUSH_MAX_TRIM] = $urandom_range(0, 255);
			end
		endcase
		for (int i = 0; i < 8; i++) begin
			apb_write(3'(i), v[i]);
		end
	endtask

	task automatic directed();
		send(mk(KIND_UNUSED, 32'hFFFF_FFFF, 1, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 1));
		send(mk(KIND_BEGIN, 32'd1000, 0, 0, 0, 0, 0, 0));
		send(mk(KIND_SEARCH, 32'd1100, 0, 0, 0, 0, 0, 0));
		send(mk(KIND_SEARCH, 32'd1500, 0, 0, 0, 0, 0, 0));
		send(mk(KIND_SEARCH, 32'd2499, 0, 0, 0, 0, 0, 0));
		send(mk(KIND_SEARCH, 32'd2500, 0, 0, 0, 0, 0, 0));
		// arc timer across the time wrap
		send(mk(KIND_BEGIN, 32'hFFFF_FF00, 1, 0, 0, 0, 0, 0));
		send(mk(KIND_SEARCH, 32'h0000_00F4, 0, 0, 0, 0, 0, 0));
		send(mk(KIND_APPROACH, 32'd4000, 0, 10'h3FF, 10'h3FF, 0, 0, 0));
		send(mk(KIND_APPROACH, 32'd4010, 0, 0, 0, 0, 0, 0));
		// side override: pending, not yet, confirmed, held, other side, release
		send(mk(KIND_APPROACH, 32'd5000, 0, 0, 0, 0, 10'd300, 0));
		send(mk(KIND_APPROACH, 32'd5049, 0, 0, 0, 0, 10'd300, 1));
		send(mk(KIND_APPROACH, 32'd5050, 0, 0, 0, 0, 10'd300, 0));
		send(mk(KIND_APPROACH, 32'd5060, 0, 0, 0, 0, 10'h3FF, 0));
		send(mk(KIND_APPROACH, 32'd5070, 0, 0, 0, 10'h3FF, 0, 0));
		send(mk(KIND_APPROACH, 32'd5080, 0, 0, 0, 0, 0, 0));
		send(mk(KIND_APPROACH, 32'd5090, 0, 0, 0, 10'h3FF, 10'h3FF, 0));
		// front steering, clamps and push decision
		send(mk(KIND_APPROACH, 32'd6000, 0, 10'h3FF, 0, 0, 0, 1));
		send(mk(KIND_APPROACH, 32'd6010, 0, 10'h3FF, 0, 0, 0, 0));
		send(mk(KIND_APPROACH, 32'd6020, 0, 10'd299, 0, 0, 0, 1));
		send(mk(KIND_APPROACH, 32'd6030, 0, 0, 10'd310, 0, 0, 0));
		send(mk(KIND_APPROACH, 32'd6040, 0, 10'd400, 10'd419, 0, 0, 0));
		send(mk(KIND_APPROACH, 32'd6050, 0, 10'd400, 10'd420, 0, 0, 0));
		// odd difference truncates toward zero
		send(mk(KIND_APPROACH, 32'd6060, 0, 10'd121, 10'd100, 0, 0, 0));
		send(mk(KIND_UNUSED, 32'd0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic random_items(input int count);
		int start, k;
		logic [9:0] r[4];
		bit win;
		start = items_sent;
		while (items_sent - start < count) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					send(mk(KIND_BEGIN, next_ms(), 1'($urandom), 10'($urandom),
						10'($urandom), 10'($urandom), 10'($urandom), 1'($urandom)));
					k = $urandom_range(3, 20);
					repeat (k) send(mk(KIND_SEARCH, next_ms(), 1'($urandom), reading(),
						reading(), reading(), reading(), 1'($urandom)));
				end
				3, 4, 5, 6, 7: begin
					// tracking run: readings mostly persist so overrides can confirm
					if ($urandom_range(0, 1) == 0) begin
						send(mk(KIND_BEGIN, next_ms(), 1'($urandom), 0, 0, 0, 0, 0));
					end
					foreach (r[i]) r[i] = reading();
					win = $urandom_range(0, 1);
					k = $urandom_range(3, 25);
					repeat (k) begin
						if ($urandom_range(0, 4) == 0) begin
							r[$urandom_range(0, 3)] = reading();
						end
						if ($urandom_range(0, 9) == 0) begin
							win = !win;
						end
						send(mk(KIND_APPROACH, next_ms(), 1'($urandom), r[0], r[1], r[2], r[3],
							win));
					end
				end
				default: begin
					k = $urandom_range(1, 6);
					repeat (k) send(mk(2'($urandom), $urandom, 1'($urandom), 10'($urandom),
						10'($urandom), 10'($urandom), 10'($urandom), 1'($urandom)));
				end
			endcase
		end
	endtask

	initial begin
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		smp.valid = 0;
		smp.kind = KIND_BEGIN;
		smp.now_ms = '0;
		smp.initial_dir = 0;
		smp.front_left = '0;
		smp.front_right = '0;
		smp.side_left = '0;
		smp.side_right = '0;
		smp.attack_window_open = 0;
		tx_idle_on = 0;
		rx_idle_on = 0;
		long_hold = 0;
		items_sent = 0;
		clock_ms = '0;
		thr_now = RST_DETECT_THRESHOLD;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		directed();
		settle();
		for (int phase = 0; phase < 8; phase++) begin
			configure(phase);
			tx_idle_on = (phase != 7) && ($urandom_range(0, 3) != 0);
			rx_idle_on = (phase != 7) && ($urandom_range(0, 3) != 0);
			// receiver holds off while the sender keeps offering
			if (phase == 3) begin
				long_hold = 300;
			end
			random_items(180);
			settle();
		end
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
